>>> rtl/core/tbo_pkg.sv
// Shared constants for the triangle/box overlap test.
`default_nettype none
package tbo_pkg;
  localparam int COORD_WIDTH_DEF = 32;
  localparam int HALF_WIDTH = 31;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int AXIS_WIDTH = 4;
  localparam logic [HALF_WIDTH-1:0] HALF_RESET = HALF_WIDTH'(32768);

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_X = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_Y = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_Z = 2'd2;

  localparam logic [AXIS_WIDTH-1:0] AXIS_WORLD_X = 4'd0;
  localparam logic [AXIS_WIDTH-1:0] AXIS_NORMAL = 4'd3;
  localparam logic [AXIS_WIDTH-1:0] AXIS_EDGE_FIRST = 4'd4;
  localparam logic [AXIS_WIDTH-1:0] AXIS_NONE = 4'd13;
  localparam int NUM_AXES = 13;
endpackage
`default_nettype wire

>>> rtl/core/tbo_mul.sv
// Two-stage signed multiplier built from two half-width partial products.
`default_nettype none
module tbo_mul #(
  parameter int AW = 34,
  parameter int BW = 34
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] prod
);
  localparam int LW = AW / 2;
  localparam int UW = AW - LW;

  logic signed [LW+BW:0]   part_lo;
  logic signed [UW+BW-1:0] part_hi;

  always_ff @(posedge clk) begin
    part_lo <= $signed({1'b0, a[LW-1:0]}) * b;
    part_hi <= $signed(a[AW-1:LW]) * b;
    prod    <= ((AW+BW)'(part_hi) <<< LW) + (AW+BW)'(part_lo);
  end
endmodule
`default_nettype wire

>>> rtl/core/tbo_delay.sv
// Fixed-length shift register that keeps payload aligned with the pipeline.
`default_nettype none
module tbo_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);
  logic [W-1:0] taps [D];

  always_ff @(posedge clk) begin
    taps[0] <= din;
    for (int i = 1; i < D; i++) begin
      taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[D-1];
endmodule
`default_nettype wire

>>> rtl/core/tbo_sep.sv
// Two-stage projection interval check of three vertex projections against a radius.
`default_nettype none
module tbo_sep #(
  parameter int DW = 40
) (
  input  logic                 clk,
  input  logic signed [DW-1:0] d0,
  input  logic signed [DW-1:0] d1,
  input  logic signed [DW-1:0] d2,
  input  logic signed [DW-1:0] r,
  input  logic                 zero,
  output logic                 sep
);
  logic signed [DW-1:0] lo01, hi01;
  logic signed [DW-1:0] lo, hi, r_q, nr;
  logic                 zero_q;

  always_comb begin
    lo01 = (d1 < d0) ? d1 : d0;
    hi01 = (d1 > d0) ? d1 : d0;
  end

  always_ff @(posedge clk) begin
    lo     <= (d2 < lo01) ? d2 : lo01;
    hi     <= (d2 > hi01) ? d2 : hi01;
    r_q    <= r;
    nr     <= -r;
    zero_q <= zero;
    sep    <= !zero_q && ((lo > r_q) || (hi < nr));
  end
endmodule
`default_nettype wire

>>> rtl/core/tbo_edge_axis.sv
// Separation test on one edge-cross-world axis.
`default_nettype none
module tbo_edge_axis
  import tbo_pkg::*;
#(
  parameter int EW = 34,
  parameter int PW = 33
) (
  input  logic                  clk,
  input  logic signed [EW-1:0]  u,
  input  logic signed [EW-1:0]  v,
  input  logic signed [PW-1:0]  q1 [3],
  input  logic signed [PW-1:0]  q2 [3],
  input  logic [HALF_WIDTH-1:0] h1,
  input  logic [HALF_WIDTH-1:0] h2,
  output logic                  sep
);
  localparam int PDW = EW + PW;
  localparam int RPW = EW + HALF_WIDTH + 2;
  localparam int DW = ((PDW + 1 > RPW + 1) ? PDW + 1 : RPW + 1) + 1;

  logic signed [PDW-1:0] pu [3];
  logic signed [PDW-1:0] pv [3];
  logic signed [RPW-1:0] ru, rv;
  logic signed [DW-1:0]  d [3];
  logic signed [DW-1:0]  r;
  logic [EW-1:0]         abs_u, abs_v;
  logic                  zero_d1, zero_d2, zero_d3;

  always_comb begin
    abs_u = u[EW-1] ? EW'(-u) : u;
    abs_v = v[EW-1] ? EW'(-v) : v;
  end

  for (genvar k = 0; k < 3; k++) begin : g_vert
    tbo_mul #(.AW(EW), .BW(PW)) u_mul_u (.clk(clk), .a(u), .b(q1[k]), .prod(pu[k]));
    tbo_mul #(.AW(EW), .BW(PW)) u_mul_v (.clk(clk), .a(v), .b(q2[k]), .prod(pv[k]));
  end

  tbo_mul #(.AW(EW+1), .BW(HALF_WIDTH+1)) u_mul_ru (
    .clk(clk), .a($signed({1'b0, abs_u})), .b($signed({1'b0, h1})), .prod(ru)
  );
  tbo_mul #(.AW(EW+1), .BW(HALF_WIDTH+1)) u_mul_rv (
    .clk(clk), .a($signed({1'b0, abs_v})), .b($signed({1'b0, h2})), .prod(rv)
  );

  always_ff @(posedge clk) begin
    zero_d1 <= (u == '0) && (v == '0);
    zero_d2 <= zero_d1;
    zero_d3 <= zero_d2;
    for (int k = 0; k < 3; k++) begin
      d[k] <= DW'(pu[k]) - DW'(pv[k]);
    end
    r <= DW'(ru) + DW'(rv);
  end

  tbo_sep #(.DW(DW)) u_sep (
    .clk(clk), .d0(d[0]), .d1(d[1]), .d2(d[2]), .r(r), .zero(zero_d3), .sep(sep)
  );
endmodule
`default_nettype wire

>>> rtl/core/triangle_box_overlap_test_top.sv
// Top level of the pipelined triangle versus box separating-axis overlap test.
// The block takes one item (a triangle and a box center) in every clock cycle;
// busy is always low. Each item yields exactly one result, shown with done for
// one cycle; the pipeline depth is set by the triangle-normal axis, which needs
// two chained multiplier stages (cross product, then projection) plus subtract,
// absolute value and compare stages. The receiver cannot stall, and items come
// out in the order they went in. Half sizes are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no item is in
// flight, as the block does not enforce it. Index 3 is ignored.
`default_nettype none
module triangle_box_overlap_test_top
  import tbo_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] vert0_x,
  input  logic signed [COORD_WIDTH-1:0] vert0_y,
  input  logic signed [COORD_WIDTH-1:0] vert0_z,
  input  logic signed [COORD_WIDTH-1:0] vert1_x,
  input  logic signed [COORD_WIDTH-1:0] vert1_y,
  input  logic signed [COORD_WIDTH-1:0] vert1_z,
  input  logic signed [COORD_WIDTH-1:0] vert2_x,
  input  logic signed [COORD_WIDTH-1:0] vert2_y,
  input  logic signed [COORD_WIDTH-1:0] vert2_z,
  input  logic signed [COORD_WIDTH-1:0] center_x,
  input  logic signed [COORD_WIDTH-1:0] center_y,
  input  logic signed [COORD_WIDTH-1:0] center_z,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [HALF_WIDTH-1:0]         cfg_data,
  output logic                          done,
  output logic                          overlaps,
  output logic [AXIS_WIDTH-1:0]         separating_axis
);
  localparam int PW = COORD_WIDTH + 1;
  localparam int EW = COORD_WIDTH + 2;
  localparam int NW = 2 * EW + 1;
  localparam int NPW = NW + PW;
  localparam int NRW = NW + HALF_WIDTH + 2;
  localparam int NDW = ((NPW + 2 > NRW + 2) ? NPW + 2 : NRW + 2) + 1;
  localparam int WDW = ((PW > HALF_WIDTH + 1) ? PW : HALF_WIDTH + 1) + 1;
  localparam int DEPTH = 11;
  localparam int P_TO_NORMAL = 5;
  localparam int EDGE_ALIGN = 4;
  localparam int WORLD_ALIGN = 8;

  logic [HALF_WIDTH-1:0] half_size_x, half_size_y, half_size_z;
  logic [HALF_WIDTH-1:0] hs [3];
  logic [DEPTH-1:0]      vld;

  logic signed [PW-1:0]  p [3][3];
  logic signed [PW-1:0]  p_n [3][3];
  logic signed [PW-1:0]  p_e [3][3];
  logic signed [EW-1:0]  e [3][3];

  assign busy = 1'b0;
  assign hs[0] = half_size_x;
  assign hs[1] = half_size_y;
  assign hs[2] = half_size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_size_x <= HALF_RESET;
      half_size_y <= HALF_RESET;
      half_size_z <= HALF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HALF_X: half_size_x <= cfg_data;
        REG_HALF_Y: half_size_y <= cfg_data;
        REG_HALF_Z: half_size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[DEPTH-2:0], start && !busy};
    end
  end

  // Box-relative vertices, indexed [vertex][component].
  always_ff @(posedge clk) begin
    p[0][0] <= PW'(vert0_x) - PW'(center_x);
    p[0][1] <= PW'(vert0_y) - PW'(center_y);
    p[0][2] <= PW'(vert0_z) - PW'(center_z);
    p[1][0] <= PW'(vert1_x) - PW'(center_x);
    p[1][1] <= PW'(vert1_y) - PW'(center_y);
    p[1][2] <= PW'(vert1_z) - PW'(center_z);
    p[2][0] <= PW'(vert2_x) - PW'(center_x);
    p[2][1] <= PW'(vert2_y) - PW'(center_y);
    p[2][2] <= PW'(vert2_z) - PW'(center_z);
    for (int c = 0; c < 3; c++) begin
      e[0][c] <= EW'(p[1][c]) - EW'(p[0][c]);
      e[1][c] <= EW'(p[2][c]) - EW'(p[1][c]);
      e[2][c] <= EW'(p[0][c]) - EW'(p[2][c]);
      p_e[0][c] <= p[0][c];
      p_e[1][c] <= p[1][c];
      p_e[2][c] <= p[2][c];
    end
  end

  // World axes.
  logic [2:0] world_sep, world_sep_al;
  for (genvar c = 0; c < 3; c++) begin : g_world
    tbo_sep #(.DW(WDW)) u_sep (
      .clk(clk), .d0(WDW'(p[0][c])), .d1(WDW'(p[1][c])), .d2(WDW'(p[2][c])),
      .r($signed(WDW'(hs[c]))), .zero(1'b0), .sep(world_sep[c])
    );
  end
  tbo_delay #(.W(3), .D(WORLD_ALIGN)) u_world_dly (
    .clk(clk), .din(world_sep), .dout(world_sep_al)
  );

  // Triangle normal axis.
  logic signed [2*EW-1:0] cp_a [3];
  logic signed [2*EW-1:0] cp_b [3];
  logic signed [NW-1:0]   n [3];
  logic signed [NW-1:0]   n_q [3];
  logic [NW-1:0]          n_abs [3];
  logic signed [NPW-1:0]  np [3][3];
  logic signed [NRW-1:0]  nr [3];
  logic signed [NDW-1:0]  nd [3];
  logic signed [NDW-1:0]  n_r;
  logic                   n_zero_q, n_zero_s;
  logic                   normal_sep;

  for (genvar c = 0; c < 3; c++) begin : g_cross
    localparam int C1 = (c + 1) % 3;
    localparam int C2 = (c + 2) % 3;
    tbo_mul #(.AW(EW), .BW(EW)) u_mul_a (
      .clk(clk), .a(e[0][C1]), .b(e[1][C2]), .prod(cp_a[c])
    );
    tbo_mul #(.AW(EW), .BW(EW)) u_mul_b (
      .clk(clk), .a(e[0][C2]), .b(e[1][C1]), .prod(cp_b[c])
    );
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      n[c]     <= NW'(cp_a[c]) - NW'(cp_b[c]);
      n_q[c]   <= n[c];
      n_abs[c] <= n[c][NW-1] ? NW'(-n[c]) : n[c];
    end
    n_zero_q <= (n[0] == '0) && (n[1] == '0) && (n[2] == '0);
  end

  for (genvar k = 0; k < 3; k++) begin : g_np_vert
    for (genvar c = 0; c < 3; c++) begin : g_np_comp
      tbo_delay #(.W(PW), .D(P_TO_NORMAL)) u_p_dly (
        .clk(clk), .din(p[k][c]), .dout(p_n[k][c])
      );
      tbo_mul #(.AW(NW), .BW(PW)) u_mul (
        .clk(clk), .a(n_q[c]), .b($signed(p_n[k][c])), .prod(np[k][c])
      );
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_nr
    tbo_mul #(.AW(NW+1), .BW(HALF_WIDTH+1)) u_mul (
      .clk(clk), .a($signed({1'b0, n_abs[c]})), .b($signed({1'b0, hs[c]})),
      .prod(nr[c])
    );
  end

  logic n_zero_d1, n_zero_d2;
  always_ff @(posedge clk) begin
    n_zero_d1 <= n_zero_q;
    n_zero_d2 <= n_zero_d1;
    n_zero_s  <= n_zero_d2;
    for (int k = 0; k < 3; k++) begin
      nd[k] <= NDW'(np[k][0]) + NDW'(np[k][1]) + NDW'(np[k][2]);
    end
    n_r <= NDW'(nr[0]) + NDW'(nr[1]) + NDW'(nr[2]);
  end

  tbo_sep #(.DW(NDW)) u_normal_sep (
    .clk(clk), .d0(nd[0]), .d1(nd[1]), .d2(nd[2]), .r(n_r), .zero(n_zero_s),
    .sep(normal_sep)
  );

  // Edge-cross-world axes, flag index 3*i+j.
  logic [8:0] edge_sep, edge_sep_al;
  for (genvar i = 0; i < 3; i++) begin : g_edge
    for (genvar j = 0; j < 3; j++) begin : g_world_ax
      localparam int CU = (j == 0) ? 2 : ((j == 1) ? 0 : 1);
      localparam int CV = (j == 0) ? 1 : ((j == 1) ? 2 : 0);
      localparam int CQ1 = (j == 0) ? 1 : ((j == 1) ? 2 : 0);
      localparam int CQ2 = (j == 0) ? 2 : ((j == 1) ? 0 : 1);
      logic signed [PW-1:0] q1 [3];
      logic signed [PW-1:0] q2 [3];
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          q1[k] = p_e[k][CQ1];
          q2[k] = p_e[k][CQ2];
        end
      end
      tbo_edge_axis #(.EW(EW), .PW(PW)) u_axis (
        .clk(clk), .u(e[i][CU]), .v(e[i][CV]), .q1(q1), .q2(q2),
        .h1(hs[CQ1]), .h2(hs[CQ2]), .sep(edge_sep[3*i+j])
      );
    end
  end
  tbo_delay #(.W(9), .D(EDGE_ALIGN)) u_edge_dly (
    .clk(clk), .din(edge_sep), .dout(edge_sep_al)
  );

  logic [NUM_AXES-1:0]   sep_all;
  logic [AXIS_WIDTH-1:0] axis_next;
  assign sep_all = {edge_sep_al, normal_sep, world_sep_al};

  always_comb begin
    axis_next = AXIS_NONE;
    for (int a = NUM_AXES - 1; a >= 0; a--) begin
      if (sep_all[a]) begin
        axis_next = AXIS_WIDTH'(a);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[DEPTH-1];
    end
    overlaps        <= (sep_all == '0);
    separating_axis <= axis_next;
  end

`ifndef SYNTHESIS
  a_overlap_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (overlaps == (separating_axis == AXIS_NONE)))
    else $error("overlap flag disagrees with the axis code");
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (separating_axis <= AXIS_NONE))
    else $error("axis code out of range");
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, DEPTH + 1))
    else $error("result without an item accepted twelve cycles earlier");
`endif
endmodule
`default_nettype wire
